// ===== hw/rtl/sdal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdal_pkg - shared definitions of the sensor daily average logger
// Widths, channel and command codes, default parameter values and the
// structures that pass between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package sdal_pkg;

  // Field and state widths.
  localparam int SAMPLE_W   = 12;
  localparam int RAW_W      = 13;
  localparam int TS_W       = 32;
  localparam int OP_W       = 2;
  localparam int SLOT_W     = 16;
  localparam int SUN_DAY_W  = 24;
  localparam int CH_DAY_W   = 20;
  localparam int CNT_W      = 6;
  localparam int FILL_W     = 3;
  localparam int AVG_W      = 16;
  localparam int CH_AVG_W   = 12;
  localparam int LAMP_W     = 2;
  localparam int ALARM_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Default configuration of the block.
  localparam int DEF_SUN_SLOTS          = 48;
  localparam int DEF_MOIST_SAMPLES      = 32;
  localparam int DEF_TEMP_SAMPLES       = 32;
  localparam int DEF_HISTORY_DAYS       = 7;
  localparam int DEF_SUN_INTERVAL_TICKS = 60;

  // Sun samples are scaled down by a fixed divisor before accumulation.
  // The quotient is taken as a multiply by a rounded-up reciprocal.
  localparam int SLOT_DIVISOR   = 30;
  localparam int SLOT_DIV_SHIFT = 17;
  localparam int SLOT_RECIP_W   = 13;
  localparam logic [SLOT_RECIP_W-1:0] SLOT_RECIP =
    SLOT_RECIP_W'(((1 << SLOT_DIV_SHIFT) + SLOT_DIVISOR - 1) / SLOT_DIVISOR);
  localparam int DIV30_W        = 8;

  // Daily averages use a reciprocal with this many fraction bits.
  localparam int AVG_SHIFT = 30;
  localparam int RECIP_W   = 31;

  // Channel codes.
  localparam logic [OP_W-1:0] OP_SUN   = 2'd0;
  localparam logic [OP_W-1:0] OP_MOIST = 2'd1;
  localparam logic [OP_W-1:0] OP_TEMP  = 2'd2;

  // Lamp commands.
  localparam logic [LAMP_W-1:0] LAMP_KEEP = 2'd0;
  localparam logic [LAMP_W-1:0] LAMP_ON   = 2'd1;
  localparam logic [LAMP_W-1:0] LAMP_OFF  = 2'd2;

  // Temperature alarm codes.
  localparam logic [ALARM_W-1:0] ALARM_NONE   = 2'd0;
  localparam logic [ALARM_W-1:0] ALARM_WARM   = 2'd1;
  localparam logic [ALARM_W-1:0] ALARM_FREEZE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SUN_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUN_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOIST_LOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH = 3'd4;

  // Classified request from the front end.
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] s;
    logic [DIV30_W-1:0]  s_div;
    logic [TS_W-1:0]     timestamp;
  } item_t;

  // Threshold registers.
  typedef struct packed {
    logic [SLOT_W-1:0]   sun_low;
    logic [SLOT_W-1:0]   sun_high;
    logic [SAMPLE_W-1:0] moist_low;
    logic [SAMPLE_W-1:0] temp_low;
    logic [SAMPLE_W-1:0] temp_high;
  } cfg_t;

  // Partial result waiting for its daily average.
  typedef struct packed {
    logic [LAMP_W-1:0]    lamp;
    logic                 pump;
    logic [ALARM_W-1:0]   alarm;
    logic                 closed;
    logic [FILL_W-1:0]    fill;
    logic [OP_W-1:0]      chan;
    logic [SUN_DAY_W-1:0] sum;
  } part_t;

endpackage

// ===== hw/rtl/sdal_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdal_fifo - two-entry request queue
// Decouples the front end from the back end so that each side can stall
// without holding up the other.
// ----------------------------------------------------------------------------
module sdal_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  // Full and empty flags come straight from the fill count.
  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointer and count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

endmodule

// ===== hw/rtl/sdal_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdal_front - sample intake and classification
// Registers each request, clamps the reading to 0..4095 and prepares the
// scaled sun contribution for the back end.
// ----------------------------------------------------------------------------
module sdal_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sdal_pkg::OP_W-1:0]      op,
  input  logic signed [sdal_pkg::RAW_W-1:0] sample,
  input  logic [sdal_pkg::TS_W-1:0]      timestamp,
  output logic                           item_valid,
  input  logic                           item_ready,
  output sdal_pkg::item_t                item
);

  import sdal_pkg::*;

  localparam int PROD_W = SAMPLE_W + SLOT_RECIP_W;

  logic [SAMPLE_W-1:0] clamped;
  logic [PROD_W-1:0]   scaled;

  // Negative readings clamp to zero; the 13-bit range tops out at 4095.
  assign clamped = sample[RAW_W-1] ? '0 : sample[SAMPLE_W-1:0];

  // Divide by the slot divisor through the reciprocal multiply.
  assign scaled = PROD_W'(clamped) * PROD_W'(SLOT_RECIP);

  // The stage accepts whenever it is empty or its request moves on.
  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.op        <= op;
      item.s         <= clamped;
      item.s_div     <= scaled[SLOT_DIV_SHIFT +: DIV30_W];
      item.timestamp <= timestamp;
    end
  end

endmodule

// ===== hw/rtl/sdal_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdal_back - accumulation, day closing and threshold tests
// First stage updates the running sums and counts and makes the threshold
// decisions; second stage divides a closed day's sum into its average,
// shifts it into the channel history and holds the result for output.
// ----------------------------------------------------------------------------
module sdal_back #(
  parameter int SUN_SLOTS          = sdal_pkg::DEF_SUN_SLOTS,
  parameter int MOIST_SAMPLES      = sdal_pkg::DEF_MOIST_SAMPLES,
  parameter int TEMP_SAMPLES       = sdal_pkg::DEF_TEMP_SAMPLES,
  parameter int HISTORY_DAYS       = sdal_pkg::DEF_HISTORY_DAYS,
  parameter int SUN_INTERVAL_TICKS = sdal_pkg::DEF_SUN_INTERVAL_TICKS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  sdal_pkg::item_t               item,
  input  sdal_pkg::cfg_t                cfg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sdal_pkg::LAMP_W-1:0]   lamp_cmd,
  output logic                          pump_start,
  output logic [sdal_pkg::ALARM_W-1:0]  temp_alarm,
  output logic                          day_closed,
  output logic [sdal_pkg::AVG_W-1:0]    day_average,
  output logic [sdal_pkg::FILL_W-1:0]   history_fill
);

  import sdal_pkg::*;

  localparam logic [TS_W-1:0] CLOSE_TICKS = TS_W'(SUN_INTERVAL_TICKS * SLOT_DIVISOR);
  localparam logic [RECIP_W-1:0] SUN_RECIP =
    RECIP_W'(((64'd1 << AVG_SHIFT) + SUN_SLOTS - 1) / SUN_SLOTS);
  localparam logic [RECIP_W-1:0] MOIST_RECIP =
    RECIP_W'(((64'd1 << AVG_SHIFT) + MOIST_SAMPLES - 1) / MOIST_SAMPLES);
  localparam logic [RECIP_W-1:0] TEMP_RECIP =
    RECIP_W'(((64'd1 << AVG_SHIFT) + TEMP_SAMPLES - 1) / TEMP_SAMPLES);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(HISTORY_DAYS);
  localparam int MUL_W = SUN_DAY_W + RECIP_W;

  // Channel state.
  logic [SLOT_W-1:0]    sun_slot_acc,        sun_slot_acc_next;
  logic [SUN_DAY_W-1:0] sun_day_acc,         sun_day_acc_next;
  logic [CNT_W-1:0]     sun_slots_done,      sun_slots_done_next;
  logic [TS_W-1:0]      sun_last_close_time, sun_last_close_time_next;
  logic [CH_DAY_W-1:0]  moist_day_acc,       moist_day_acc_next;
  logic [CNT_W-1:0]     moist_samples_done,  moist_samples_done_next;
  logic [CH_DAY_W-1:0]  temp_day_acc,        temp_day_acc_next;
  logic [CNT_W-1:0]     temp_samples_done,   temp_samples_done_next;
  logic [SAMPLE_W-1:0]  latest_moist,        latest_moist_next;
  logic [SAMPLE_W-1:0]  latest_temp,         latest_temp_next;
  logic [FILL_W-1:0]    sun_fill,            sun_fill_next;
  logic [FILL_W-1:0]    moist_fill,          moist_fill_next;
  logic [FILL_W-1:0]    temp_fill,           temp_fill_next;

  logic [SLOT_W-1:0]    sun_history   [HISTORY_DAYS];
  logic [SAMPLE_W-1:0]  moist_history [HISTORY_DAYS];
  logic [SAMPLE_W-1:0]  temp_history  [HISTORY_DAYS];

  // Pipeline control.
  logic    p1_valid;
  part_t   p1;
  part_t   part_next;
  logic    p1_adv;
  logic    pop;
  logic    load_out;

  // First stage temporaries.
  logic [SLOT_W:0]      slot_sum;
  logic [SLOT_W-1:0]    slot_sat;
  logic [SLOT_W-1:0]    sun_val;
  logic [TS_W-1:0]      elapsed;
  logic [SUN_DAY_W-1:0] sun_day_sum;
  logic [CNT_W-1:0]     sun_done_inc;
  logic [CH_DAY_W-1:0]  moist_day_sum;
  logic [CNT_W-1:0]     moist_done_inc;
  logic [CH_DAY_W-1:0]  temp_day_sum;
  logic [CNT_W-1:0]     temp_done_inc;

  // Second stage temporaries.
  logic [RECIP_W-1:0]   recip;
  logic [MUL_W-1:0]     quot_prod;
  logic [AVG_W-1:0]     avg;

  // Handshakes between the queue, the two stages and the output register.
  assign p1_adv     = !out_valid || out_ready;
  assign item_ready = !p1_valid || p1_adv;
  assign pop        = item_valid && item_ready;
  assign load_out   = p1_valid && p1_adv;

  // Running sums, slot closing and day closing for the request at the head.
  always_comb begin
    slot_sum       = (SLOT_W + 1)'(sun_slot_acc) + (SLOT_W + 1)'(item.s_div);
    slot_sat       = slot_sum[SLOT_W] ? '1 : slot_sum[SLOT_W-1:0];
    elapsed        = item.timestamp - sun_last_close_time;
    sun_day_sum    = sun_day_acc + SUN_DAY_W'(slot_sat);
    sun_done_inc   = sun_slots_done + CNT_W'(1);
    moist_day_sum  = moist_day_acc + CH_DAY_W'(item.s);
    moist_done_inc = moist_samples_done + CNT_W'(1);
    temp_day_sum   = temp_day_acc + CH_DAY_W'(item.s);
    temp_done_inc  = temp_samples_done + CNT_W'(1);

    sun_slot_acc_next        = sun_slot_acc;
    sun_day_acc_next         = sun_day_acc;
    sun_slots_done_next      = sun_slots_done;
    sun_last_close_time_next = sun_last_close_time;
    moist_day_acc_next       = moist_day_acc;
    moist_samples_done_next  = moist_samples_done;
    temp_day_acc_next        = temp_day_acc;
    temp_samples_done_next   = temp_samples_done;
    latest_moist_next        = latest_moist;
    latest_temp_next         = latest_temp;
    sun_fill_next            = sun_fill;
    moist_fill_next          = moist_fill;
    temp_fill_next           = temp_fill;
    sun_val                  = sun_slot_acc;

    part_next        = '0;
    part_next.chan   = item.op;

    case (item.op)
      OP_SUN: begin
        sun_slot_acc_next = slot_sat;
        sun_val           = slot_sat;
        if (elapsed >= CLOSE_TICKS) begin
          sun_last_close_time_next = item.timestamp;
          sun_slot_acc_next        = '0;
          if (sun_done_inc >= CNT_W'(SUN_SLOTS)) begin
            part_next.closed    = 1'b1;
            part_next.sum       = sun_day_sum;
            sun_day_acc_next    = '0;
            sun_slots_done_next = '0;
            if (sun_fill < FILL_MAX) sun_fill_next = sun_fill + FILL_W'(1);
          end else begin
            sun_day_acc_next    = sun_day_sum;
            sun_slots_done_next = sun_done_inc;
          end
        end
        part_next.fill = sun_fill_next;
      end
      OP_MOIST: begin
        latest_moist_next = item.s;
        if (moist_done_inc >= CNT_W'(MOIST_SAMPLES)) begin
          part_next.closed        = 1'b1;
          part_next.sum           = SUN_DAY_W'(moist_day_sum);
          moist_day_acc_next      = '0;
          moist_samples_done_next = '0;
          if (moist_fill < FILL_MAX) moist_fill_next = moist_fill + FILL_W'(1);
        end else begin
          moist_day_acc_next      = moist_day_sum;
          moist_samples_done_next = moist_done_inc;
        end
        part_next.fill = moist_fill_next;
      end
      OP_TEMP: begin
        latest_temp_next = item.s;
        if (temp_done_inc >= CNT_W'(TEMP_SAMPLES)) begin
          part_next.closed       = 1'b1;
          part_next.sum          = SUN_DAY_W'(temp_day_sum);
          temp_day_acc_next      = '0;
          temp_samples_done_next = '0;
          if (temp_fill < FILL_MAX) temp_fill_next = temp_fill + FILL_W'(1);
        end else begin
          temp_day_acc_next      = temp_day_sum;
          temp_samples_done_next = temp_done_inc;
        end
        part_next.fill = temp_fill_next;
      end
      default: begin
        // Unused channel code: state is left alone, fill reads as zero.
      end
    endcase

    // Threshold tests; switching off wins over switching on, warm over freezing.
    if (sun_val > cfg.sun_high) part_next.lamp = LAMP_OFF;
    else if (sun_val < cfg.sun_low) part_next.lamp = LAMP_ON;
    else part_next.lamp = LAMP_KEEP;

    part_next.pump = (latest_moist_next < cfg.moist_low);

    if (latest_temp_next > cfg.temp_high) part_next.alarm = ALARM_WARM;
    else if (latest_temp_next < cfg.temp_low) part_next.alarm = ALARM_FREEZE;
    else part_next.alarm = ALARM_NONE;
  end

  // Channel state registers, updated as each request leaves the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      sun_slot_acc        <= '0;
      sun_day_acc         <= '0;
      sun_slots_done      <= '0;
      sun_last_close_time <= '0;
      moist_day_acc       <= '0;
      moist_samples_done  <= '0;
      temp_day_acc        <= '0;
      temp_samples_done   <= '0;
      latest_moist        <= '0;
      latest_temp         <= '0;
      sun_fill            <= '0;
      moist_fill          <= '0;
      temp_fill           <= '0;
    end else if (pop) begin
      sun_slot_acc        <= sun_slot_acc_next;
      sun_day_acc         <= sun_day_acc_next;
      sun_slots_done      <= sun_slots_done_next;
      sun_last_close_time <= sun_last_close_time_next;
      moist_day_acc       <= moist_day_acc_next;
      moist_samples_done  <= moist_samples_done_next;
      temp_day_acc        <= temp_day_acc_next;
      temp_samples_done   <= temp_samples_done_next;
      latest_moist        <= latest_moist_next;
      latest_temp         <= latest_temp_next;
      sun_fill            <= sun_fill_next;
      moist_fill          <= moist_fill_next;
      temp_fill           <= temp_fill_next;
    end
  end

  // Stage register between the update and the divide.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (pop) begin
      p1_valid <= 1'b1;
    end else if (p1_adv) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) p1 <= part_next;
  end

  // Day average as a multiply by the reciprocal of the channel's day length.
  always_comb begin
    case (p1.chan)
      OP_SUN:   recip = SUN_RECIP;
      OP_MOIST: recip = MOIST_RECIP;
      default:  recip = TEMP_RECIP;
    endcase
    quot_prod = MUL_W'(p1.sum) * MUL_W'(recip);
    if (!p1.closed) avg = '0;
    else if (p1.chan == OP_SUN) avg = quot_prod[AVG_SHIFT +: AVG_W];
    else avg = AVG_W'(quot_prod[AVG_SHIFT +: CH_AVG_W]);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p1_adv) begin
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      lamp_cmd     <= p1.lamp;
      pump_start   <= p1.pump;
      temp_alarm   <= p1.alarm;
      day_closed   <= p1.closed;
      day_average  <= avg;
      history_fill <= p1.fill;
    end
  end

  // History shift: the newest average enters at the front, the oldest drops.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DAYS; i++) begin
        sun_history[i]   <= '0;
        moist_history[i] <= '0;
        temp_history[i]  <= '0;
      end
    end else if (load_out && p1.closed) begin
      case (p1.chan)
        OP_SUN: begin
          sun_history[0] <= avg;
          for (int i = 1; i < HISTORY_DAYS; i++) sun_history[i] <= sun_history[i-1];
        end
        OP_MOIST: begin
          moist_history[0] <= avg[CH_AVG_W-1:0];
          for (int i = 1; i < HISTORY_DAYS; i++) moist_history[i] <= moist_history[i-1];
        end
        default: begin
          temp_history[0] <= avg[CH_AVG_W-1:0];
          for (int i = 1; i < HISTORY_DAYS; i++) temp_history[i] <= temp_history[i-1];
        end
      endcase
    end
  end

  // A closed day always leaves at least one stored average.
  a_closed_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && day_closed |-> history_fill != '0)
    else $error("day closed with empty history");

  // The average is zero unless a day was closed.
  a_avg_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !day_closed |-> day_average == '0)
    else $error("day average set without a closed day");

  // Counters restart before they reach the day length.
  a_sun_count: assert property (@(posedge clk) disable iff (rst)
    sun_slots_done < CNT_W'(SUN_SLOTS) && moist_samples_done < CNT_W'(MOIST_SAMPLES)
    && temp_samples_done < CNT_W'(TEMP_SAMPLES))
    else $error("day counter past its limit");

  // A partial result held behind a stalled output is not lost.
  a_p1_hold: assert property (@(posedge clk) disable iff (rst)
    p1_valid && !p1_adv |=> p1_valid)
    else $error("stage result dropped under stall");

  // Fill counts never pass the history depth.
  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    sun_fill <= FILL_MAX && moist_fill <= FILL_MAX && temp_fill <= FILL_MAX)
    else $error("history count past depth");

endmodule

// ===== hw/rtl/sensor_daily_average_logger_top.sv =====
`timescale 1ns / 1ps
// Path: intake register, queue, update stage, then the divide into the output register.
// Throughput: one sample per cycle while the output is not stalled; the update
// stage closes slots and days in one pass.
// Reset: synchronous, active high; clears all sums, counts, histories and
// restores the threshold registers: lows to zero, highs to all ones.
// ----------------------------------------------------------------------------
// sensor_daily_average_logger_top - daily sensor average logger
// Accepts timestamped sun, moisture and temperature samples, keeps daily
// averages per channel and reports lamp, pump and temperature alarm commands.
// ----------------------------------------------------------------------------
module sensor_daily_average_logger_top #(
  parameter int SUN_SLOTS          = sdal_pkg::DEF_SUN_SLOTS,
  parameter int MOIST_SAMPLES      = sdal_pkg::DEF_MOIST_SAMPLES,
  parameter int TEMP_SAMPLES       = sdal_pkg::DEF_TEMP_SAMPLES,
  parameter int HISTORY_DAYS       = sdal_pkg::DEF_HISTORY_DAYS,
  parameter int SUN_INTERVAL_TICKS = sdal_pkg::DEF_SUN_INTERVAL_TICKS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sdal_pkg::OP_W-1:0]          op,
  input  logic signed [sdal_pkg::RAW_W-1:0]  sample,
  input  logic [sdal_pkg::TS_W-1:0]          timestamp,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sdal_pkg::LAMP_W-1:0]        lamp_cmd,
  output logic                               pump_start,
  output logic [sdal_pkg::ALARM_W-1:0]       temp_alarm,
  output logic                               day_closed,
  output logic [sdal_pkg::AVG_W-1:0]         day_average,
  output logic [sdal_pkg::FILL_W-1:0]        history_fill,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sdal_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sdal_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import sdal_pkg::*;

  logic  front_valid;
  logic  front_ready;
  item_t front_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;
  cfg_t  cfg;

  // Threshold registers; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sun_low   <= '0;
      cfg.sun_high  <= '1;
      cfg.moist_low <= '0;
      cfg.temp_low  <= '0;
      cfg.temp_high <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SUN_LOW:   cfg.sun_low   <= cfg_data;
        CFG_SUN_HIGH:  cfg.sun_high  <= cfg_data;
        CFG_MOIST_LOW: cfg.moist_low <= cfg_data[SAMPLE_W-1:0];
        CFG_TEMP_LOW:  cfg.temp_low  <= cfg_data[SAMPLE_W-1:0];
        CFG_TEMP_HIGH: cfg.temp_high <= cfg_data[SAMPLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Intake and classification.
  sdal_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .sample     (sample),
    .timestamp  (timestamp),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  // Request queue between the two halves.
  sdal_fifo #(
    .WIDTH ($bits(item_t))
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_item)
  );

  // Accumulation, averaging and threshold tests.
  sdal_back #(
    .SUN_SLOTS          (SUN_SLOTS),
    .MOIST_SAMPLES      (MOIST_SAMPLES),
    .TEMP_SAMPLES       (TEMP_SAMPLES),
    .HISTORY_DAYS       (HISTORY_DAYS),
    .SUN_INTERVAL_TICKS (SUN_INTERVAL_TICKS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (q_valid),
    .item_ready   (q_ready),
    .item         (q_item),
    .cfg          (cfg),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .lamp_cmd     (lamp_cmd),
    .pump_start   (pump_start),
    .temp_alarm   (temp_alarm),
    .day_closed   (day_closed),
    .day_average  (day_average),
    .history_fill (history_fill)
  );

endmodule
